// ===== rtl/core/pida_pkg.sv =====
// Package for the positional insert/delete array.
// Holds field widths, opcode, status and controller codes, and the command and
// status structs between the controller and the datapath. No dependencies.
package pida_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int WORD_W        = 32;
    localparam int COUNT_W       = 7;
    localparam int INDEX_W       = 6;
    localparam int OPCODE_W      = 2;
    localparam int STATUS_W      = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT   = 2'd0,
        OP_DELETE   = 2'd1,
        OP_TRAVERSE = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BAD_POS = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE     = 1'b0,
        S_TRAVERSE = 1'b1
    } state_t;

    typedef enum logic [1:0] {
        DP_HOLD   = 2'd0,
        DP_INSERT = 2'd1,
        DP_DELETE = 2'd2,
        DP_ROTATE = 2'd3
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        logic    idx_clear;
        logic    res_load;
        status_t res_status;
        logic    res_elem;
        logic    res_last;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic ins_ok;
        logic del_ok;
        logic last_elem;
    } dp_stat_t;

endpackage

// ===== rtl/core/pida_ctrl.sv =====
// Controller for the positional insert/delete array.
// Decodes transactions, checks them against datapath status and sequences the
// traverse. Depends on pida_pkg.
module pida_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [pida_pkg::OPCODE_W-1:0]   opcode,
    input  pida_pkg::dp_stat_t              stat,
    output pida_pkg::dp_cmd_t               cmd,
    output logic                            busy
);
    import pida_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.op         = DP_HOLD;
        cmd.idx_clear  = 1'b0;
        cmd.res_load   = 1'b0;
        cmd.res_status = ST_OK;
        cmd.res_elem   = 1'b0;
        cmd.res_last   = 1'b0;
        busy           = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (opcode_t'(opcode))
                        OP_INSERT:
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_last = 1'b1;
                            if (stat.full)
                            begin
                                cmd.res_status = ST_FULL;
                            end
                            else if (!stat.ins_ok)
                            begin
                                cmd.res_status = ST_BAD_POS;
                            end
                            else
                            begin
                                cmd.op = DP_INSERT;
                            end
                        end
                        OP_DELETE:
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_last = 1'b1;
                            if (!stat.del_ok)
                            begin
                                cmd.res_status = ST_BAD_POS;
                            end
                            else
                            begin
                                cmd.op = DP_DELETE;
                            end
                        end
                        OP_TRAVERSE:
                        begin
                            if (stat.empty)
                            begin
                                cmd.res_load   = 1'b1;
                                cmd.res_last   = 1'b1;
                                cmd.res_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.idx_clear = 1'b1;
                                state_next    = S_TRAVERSE;
                            end
                        end
                        default:
                        begin
                            // The unused opcode is dropped without a result.
                        end
                    endcase
                end
            end
            S_TRAVERSE:
            begin
                // Each cycle sends the head cell and rotates the stored
                // elements by one, so the order is restored at the end.
                busy         = 1'b1;
                cmd.op       = DP_ROTATE;
                cmd.res_load = 1'b1;
                cmd.res_elem = 1'b1;
                cmd.res_last = stat.last_elem;
                if (stat.last_elem)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_trav_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TRAVERSE |-> !stat.empty)
        else $error("traverse running on an empty array");

    a_trav_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TRAVERSE && stat.last_elem |=> state_reg == S_IDLE)
        else $error("traverse did not end after the last element");

    a_partial_in_trav: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load && !cmd.res_last |-> state_reg == S_TRAVERSE)
        else $error("non-final result outside a traverse");

endmodule

// ===== rtl/core/pida_datapath.sv =====
// Datapath for the positional insert/delete array: a row of word cells that
// shift or rotate as a whole, the element count, the traverse index and the
// result registers. Depends on pida_pkg.
module pida_datapath #(
    parameter int DEPTH = pida_pkg::DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  pida_pkg::dp_cmd_t               cmd,
    input  logic [pida_pkg::COUNT_W-1:0]    position,
    input  logic [pida_pkg::WORD_W-1:0]     new_value,
    output pida_pkg::dp_stat_t              stat,
    output logic                            done,
    output logic [pida_pkg::STATUS_W-1:0]   status,
    output logic [pida_pkg::COUNT_W-1:0]    element_count,
    output logic [pida_pkg::INDEX_W-1:0]    element_index,
    output logic [pida_pkg::WORD_W-1:0]     element_value,
    output logic                            last_result
);
    import pida_pkg::*;

    logic [WORD_W-1:0]   cell_reg [DEPTH];
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [INDEX_W-1:0]  idx_reg;
    logic [COUNT_W-1:0]  count_m1;

    logic                done_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [COUNT_W-1:0]  res_count_reg;
    logic [INDEX_W-1:0]  res_index_reg;
    logic [WORD_W-1:0]   res_value_reg;
    logic                res_last_reg;

    assign count_m1 = count_reg - COUNT_W'(1);

    assign stat.full      = (count_reg == COUNT_W'(DEPTH));
    assign stat.empty     = (count_reg == '0);
    assign stat.ins_ok    = (position <= count_reg);
    assign stat.del_ok    = (position < count_reg);
    assign stat.last_elem = ({1'b0, idx_reg} == count_m1);

    // Cells above the count hold stale data and are never sent out.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_W-1:0] lower;
        logic [WORD_W-1:0] upper;
        logic [WORD_W-1:0] cell_next;

        if (i == 0)
        begin : g_low_edge
            assign lower = cell_reg[i];
        end
        else
        begin : g_low
            assign lower = cell_reg[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_high_edge
            assign upper = cell_reg[i];
        end
        else
        begin : g_high
            assign upper = cell_reg[i+1];
        end

        always_comb
        begin
            cell_next = cell_reg[i];
            unique case (cmd.op)
                DP_INSERT:
                begin
                    if (COUNT_W'(i) == position)
                    begin
                        cell_next = new_value;
                    end
                    else if (COUNT_W'(i) > position)
                    begin
                        cell_next = lower;
                    end
                end
                DP_DELETE:
                begin
                    if (COUNT_W'(i) >= position)
                    begin
                        cell_next = upper;
                    end
                end
                DP_ROTATE:
                begin
                    if (COUNT_W'(i) == count_m1)
                    begin
                        cell_next = cell_reg[0];
                    end
                    else
                    begin
                        cell_next = upper;
                    end
                end
                default:
                begin
                    cell_next = cell_reg[i];
                end
            endcase
        end

        always_ff @(posedge clk)
        begin
            cell_reg[i] <= cell_next;
        end
    end

    always_comb
    begin
        unique case (cmd.op)
            DP_INSERT: count_next = count_reg + COUNT_W'(1);
            DP_DELETE: count_next = count_m1;
            default:   count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.res_load;
            if (cmd.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (cmd.op == DP_ROTATE)
            begin
                idx_reg <= idx_reg + INDEX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            status_reg    <= cmd.res_status;
            res_count_reg <= count_next;
            res_index_reg <= cmd.res_elem ? idx_reg : '0;
            res_value_reg <= cmd.res_elem ? cell_reg[0] : '0;
            res_last_reg  <= cmd.res_last;
        end
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign element_count = res_count_reg;
    assign element_index = res_index_reg;
    assign element_value = res_value_reg;
    assign last_result   = res_last_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(DEPTH))
        else $error("element count above depth");

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == DP_INSERT |=> count_reg == $past(count_reg) + COUNT_W'(1))
        else $error("insert did not raise the count");

    a_rotate_idx: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == DP_ROTATE && !stat.last_elem |=> idx_reg == $past(idx_reg) + INDEX_W'(1))
        else $error("traverse index did not advance");

endmodule

// ===== rtl/core/positional_insert_delete_array.sv =====
// Positional insert/delete array. Insert, delete and a traverse of an empty
// array give their single result in the cycle after the transaction is accepted.
// A traverse of n elements gives one result a cycle and holds busy while it runs,
// sending the head cell as it rotates the cell row; a new transaction is taken in
// the cycle of the last result.
// Reset empties the array at once; cell contents stay undefined until written.
module positional_insert_delete_array #(
    parameter int DEPTH = pida_pkg::DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [pida_pkg::OPCODE_W-1:0]   opcode,
    input  logic [pida_pkg::COUNT_W-1:0]    position,
    input  logic [pida_pkg::WORD_W-1:0]     new_value,
    output logic                            done,
    output logic [pida_pkg::STATUS_W-1:0]   status,
    output logic [pida_pkg::COUNT_W-1:0]    element_count,
    output logic [pida_pkg::INDEX_W-1:0]    element_index,
    output logic [pida_pkg::WORD_W-1:0]     element_value,
    output logic                            last_result
);
    import pida_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    pida_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    pida_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .position      (position),
        .new_value     (new_value),
        .stat          (stat),
        .done          (done),
        .status        (status),
        .element_count (element_count),
        .element_index (element_index),
        .element_value (element_value),
        .last_result   (last_result)
    );

endmodule

// ===== bench/positional_insert_delete_array_test.sv =====
// Self-checking testbench for positional_insert_delete_array.
// Sends insert, delete and traverse transactions, predicts each result from a shadow
// copy of the array and checks the results in order. Depends on pida_pkg and the RTL.
module positional_insert_delete_array_test;
    import pida_pkg::*;

    localparam int CAPACITY = DEPTH_DEFAULT;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam logic [COUNT_W-1:0] POS_MAX = '1;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic [INDEX_W-1:0]  index;
        logic [WORD_W-1:0]   value;
        logic                last;
    } array_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [OPCODE_W-1:0] opcode = '0;
    logic [COUNT_W-1:0]  position = '0;
    logic [WORD_W-1:0]   new_value = '0;
    logic                busy;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  element_count;
    logic [INDEX_W-1:0]  element_index;
    logic [WORD_W-1:0]   element_value;
    logic                last_result;

    logic [WORD_W-1:0] shadow_words [CAPACITY];
    int                shadow_count = 0;
    array_result_t     expected_results [$];
    int                error_count = 0;
    int                idle_pct = 0;

    always #10 clk = ~clk;

    positional_insert_delete_array dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .opcode        (opcode),
        .position      (position),
        .new_value     (new_value),
        .done          (done),
        .status        (status),
        .element_count (element_count),
        .element_index (element_index),
        .element_value (element_value),
        .last_result   (last_result)
    );

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 100)
            $display("ERROR at %0t: %s", $time, what);
    endtask

    task automatic push_status_result(input logic [STATUS_W-1:0] code);
        array_result_t r;
        r.status = code;
        r.count  = shadow_count[COUNT_W-1:0];
        r.index  = '0;
        r.value  = '0;
        r.last   = 1'b1;
        expected_results.push_back(r);
    endtask

    // Applies one accepted transaction to the shadow array and queues its results.
    task automatic apply_array_op(input logic [OPCODE_W-1:0] op,
                                  input logic [COUNT_W-1:0] pos,
                                  input logic [WORD_W-1:0] val);
        array_result_t r;
        case (op)
            OP_INSERT:
            begin
                // A full array is reported before a bad position.
                if (shadow_count >= CAPACITY)
                    push_status_result(ST_FULL);
                else if (pos > shadow_count)
                    push_status_result(ST_BAD_POS);
                else
                begin
                    for (int i = shadow_count; i > pos; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[pos[INDEX_W-1:0]] = val;
                    shadow_count++;
                    push_status_result(ST_OK);
                end
            end
            OP_DELETE:
            begin
                if (pos >= shadow_count)
                    push_status_result(ST_BAD_POS);
                else
                begin
                    for (int i = pos; i + 1 < shadow_count; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_count--;
                    push_status_result(ST_OK);
                end
            end
            OP_TRAVERSE:
            begin
                if (shadow_count == 0)
                    push_status_result(ST_EMPTY);
                for (int i = 0; i < shadow_count; i++)
                begin
                    r.status = ST_OK;
                    r.count  = shadow_count[COUNT_W-1:0];
                    r.index  = i[INDEX_W-1:0];
                    r.value  = shadow_words[i];
                    r.last   = (i + 1 == shadow_count);
                    expected_results.push_back(r);
                end
            end
            default:
            begin
                // The unused opcode changes nothing and gives no result.
            end
        endcase
    endtask

    // Holds the transaction on the ports until the block takes it.
    task automatic send_item(input logic [OPCODE_W-1:0] op,
                             input logic [COUNT_W-1:0] pos,
                             input logic [WORD_W-1:0] val);
        start     <= 1'b1;
        opcode    <= op;
        position  <= pos;
        new_value <= val;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        apply_array_op(op, pos, val);
    endtask

    task automatic sender_gap();
        while ($urandom_range(99) < idle_pct)
        begin
            start     <= 1'b0;
            opcode    <= OPCODE_W'($urandom);
            position  <= COUNT_W'($urandom);
            new_value <= $urandom;
            @(posedge clk);
        end
    endtask

    task automatic wait_for_drain();
        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(11))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Mostly legal positions with the edges favored; the rest are one past the end or random over the port range.
    function automatic logic [COUNT_W-1:0] random_position(input logic [OPCODE_W-1:0] op);
        int top;
        int roll;
        top  = (op == OP_INSERT) ? shadow_count : shadow_count - 1;
        roll = $urandom_range(99);
        if (roll < 80 && top >= 0)
        begin
            case ($urandom_range(3))
                0: return '0;
                1: return top[COUNT_W-1:0];
                default: return COUNT_W'($urandom_range(top));
            endcase
        end
        if (roll < 90 && top + 1 <= POS_MAX)
            return top[COUNT_W-1:0] + 1'b1;
        return COUNT_W'($urandom_range(POS_MAX));
    endfunction

    task automatic test_directed_cases();
        idle_pct = 0;
        send_item(OP_TRAVERSE, 7'd0, random_word());
        send_item(OP_DELETE, 7'd0, '0);
        send_item(OP_INSERT, 7'd1, 32'h1234_5678);
        send_item(OP_INSERT, 7'd0, 32'h8000_0000);
        send_item(OP_INSERT, 7'd1, 32'h7fff_ffff);
        send_item(OP_INSERT, 7'd0, 32'h0000_0000);
        send_item(OP_INSERT, 7'd1, 32'hffff_ffff);
        send_item(OP_INSERT, 7'd4, 32'h5555_5555);
        send_item(OP_INSERT, 7'd6, 32'haaaa_aaaa);
        send_item(OP_INSERT, POS_MAX, 32'h0f0f_0f0f);
        send_item(OP_INSERT, 7'd64, 32'hf0f0_f0f0);
        send_item(OP_TRAVERSE, POS_MAX, random_word());
        send_item(OP_UNUSED, 7'd0, 32'hdead_beef);
        send_item(OP_DELETE, 7'd5, '0);
        send_item(OP_DELETE, POS_MAX, '0);
        send_item(OP_DELETE, 7'd2, '0);
        send_item(OP_DELETE, 7'd0, '0);
        send_item(OP_DELETE, 7'd2, '0);
        send_item(OP_TRAVERSE, 7'd0, '0);
        send_item(OP_DELETE, 7'd1, '0);
        send_item(OP_DELETE, 7'd0, '0);
        send_item(OP_TRAVERSE, 7'd0, '0);
    endtask

    task automatic test_full_array();
        idle_pct = 0;
        while (shadow_count < CAPACITY)
            send_item(OP_INSERT, COUNT_W'($urandom_range(shadow_count)), random_word());
        send_item(OP_INSERT, 7'd64, random_word());
        send_item(OP_INSERT, POS_MAX, random_word());
        send_item(OP_INSERT, 7'd0, random_word());
        send_item(OP_TRAVERSE, 7'd0, '0);
        send_item(OP_DELETE, 7'd64, '0);
        send_item(OP_DELETE, 7'd63, '0);
        send_item(OP_INSERT, 7'd63, 32'h8000_0000);
        send_item(OP_DELETE, 7'd0, '0);
        send_item(OP_TRAVERSE, 7'd0, '0);
    endtask

    // Bursts lean toward growth, shrinkage or balance so the count sweeps its range.
    task automatic test_random_traffic(input int item_total, input int gap_pct);
        int sent;
        int grow_pct;
        int roll;
        logic [OPCODE_W-1:0] op;
        sent     = 0;
        grow_pct = 50;
        idle_pct = gap_pct;
        while (sent < item_total)
        begin
            if (sent % 20 == 0)
            begin
                case ($urandom_range(2))
                    0: grow_pct = 85;
                    1: grow_pct = 15;
                    default: grow_pct = 50;
                endcase
            end
            roll = $urandom_range(99);
            if (roll < 3)
                op = OP_UNUSED;
            else if (roll < 12)
                op = OP_TRAVERSE;
            else if ($urandom_range(99) < grow_pct)
                op = OP_INSERT;
            else
                op = OP_DELETE;
            sender_gap();
            send_item(op, random_position(op), random_word());
            if (op != OP_UNUSED)
                sent++;
        end
    endtask

    always @(posedge clk)
    begin
        array_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result: status %0d count %0d index %0d",
                                          status, element_count, element_index));
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status || element_count !== want.count ||
                    element_index !== want.index || element_value !== want.value ||
                    last_result !== want.last)
                    report_mismatch($sformatf(
                        "got st %0d cnt %0d idx %0d val %h last %b, want %0d %0d %0d %h %b",
                        status, element_count, element_index, element_value, last_result,
                        want.status, want.count, want.index, want.value, want.last));
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        // Let every result arrive before filling the array.
        wait_for_drain();
        test_full_array();
        test_random_traffic(100, 0);
        test_random_traffic(100, 84);
        test_random_traffic(100, 9);
        wait_for_drain();
        repeat (20) @(posedge clk);
        if (expected_results.size() == 0 && error_count == 0)
            $display("PASS positional_insert_delete_array");
        else
            $display("FAIL positional_insert_delete_array");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL positional_insert_delete_array");
        $finish;
    end

endmodule
